// File: rtl/llrb_pkg.sv
package llrb_pkg;

    localparam int SEQ_W = 48;
    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [7:0]       data_byte;
        logic [SEQ_W-1:0] read_seq;
    } llrb_req_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             read_valid;
        logic [SEQ_W-1:0] head_seq;
        logic [SEQ_W-1:0] tail_seq;
    } llrb_rsp_t;

endpackage

// File: rtl/line_log_ring_buffer_core.sv
// Read beat: the ring read is registered in rd_q_reg, then S_READ registers the result.
// Push that does not end a line (or is discarded): result registered on acceptance.
// Line commit: evict tail lines (S_EVAL/S_EV_CHK), copy bytes (S_CP_RD/S_CP_WR), S_DONE.
// One beat in flight at a time.
// rst_n asynchronous, active low: clears counters and control; the ring and
// line store are not cleared and need no sweep after reset.
module line_log_ring_buffer_core #(
    parameter int LOG_DEPTH = 16384,
    parameter int LINE_MAX  = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  llrb_pkg::llrb_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output llrb_pkg::llrb_rsp_t rsp
);

    localparam int AW  = $clog2(LOG_DEPTH);
    localparam int LSW = $clog2(LINE_MAX);
    localparam int FW  = $clog2(LINE_MAX + 1);
    localparam int SW  = llrb_pkg::SEQ_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_EV_CHK = 3'd3;
    localparam logic [2:0] S_CP_RD  = 3'd4;
    localparam logic [2:0] S_CP_WR  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [7:0] log_ring [LOG_DEPTH];
    logic [7:0] line_store [LINE_MAX];

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [AW-1:0] held_reg, held_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] len_reg, len_next;
    logic [FW-1:0] cnt_reg, cnt_next;
    logic          disc_reg, disc_next;
    logic          in_line_reg, in_line_next;
    logic [SW-1:0] seq_reg, seq_next;
    logic          rsp_valid_reg, rsp_valid_next;
    llrb_pkg::llrb_rsp_t rsp_reg, rsp_next;

    logic [7:0]    rd_q_reg;
    logic [7:0]    ls_q_reg;
    logic [AW-1:0] ring_raddr;
    logic          ring_we;
    logic          ls_we;
    logic [7:0]    ls_wdata;

    logic          accept;
    logic          push_nl;
    logic          last_slot;
    logic [AW:0]   need_sum;
    logic          need_room;
    logic [SW-1:0] rd_off;
    logic          rd_hit;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign push_nl   = (req.data_byte == llrb_pkg::NEWLINE);
    assign last_slot = (fill_reg == FW'(LINE_MAX - 1));
    assign ls_wdata  = (!push_nl && last_slot) ? llrb_pkg::NEWLINE : req.data_byte;
    assign need_sum  = {1'b0, held_reg} + (AW+1)'(len_reg);
    assign need_room = (need_sum >= (AW+1)'(LOG_DEPTH));
    assign rd_off    = seq_reg - tail_reg;
    assign rd_hit    = (rd_off < {{(SW-AW){1'b0}}, held_reg});

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        disc_next      = disc_reg;
        in_line_next   = in_line_reg;
        seq_next       = seq_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ring_we        = 1'b0;
        ls_we          = 1'b0;
        ring_raddr     = req.read_seq[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == llrb_pkg::OP_READ)
                    begin
                        seq_next   = req.read_seq;
                        state_next = S_READ;
                    end
                    else if (disc_reg)
                    begin
                        if (push_nl)
                        begin
                            disc_next = 1'b0;
                        end
                        rsp_valid_next      = 1'b1;
                        rsp_next.read_byte  = '0;
                        rsp_next.read_valid = 1'b0;
                        rsp_next.head_seq   = head_reg;
                        rsp_next.tail_seq   = tail_reg;
                    end
                    else
                    begin
                        ls_we = 1'b1;
                        if (push_nl || last_slot)
                        begin
                            len_next   = fill_reg + FW'(1);
                            fill_next  = '0;
                            disc_next  = !push_nl;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            fill_next           = fill_reg + FW'(1);
                            rsp_valid_next      = 1'b1;
                            rsp_next.read_byte  = '0;
                            rsp_next.read_valid = 1'b0;
                            rsp_next.head_seq   = head_reg;
                            rsp_next.tail_seq   = tail_reg;
                        end
                    end
                end
            end
            S_READ:
            begin
                rsp_valid_next      = 1'b1;
                rsp_next.read_byte  = rd_hit ? rd_q_reg : 8'd0;
                rsp_next.read_valid = rd_hit;
                rsp_next.head_seq   = head_reg;
                rsp_next.tail_seq   = tail_reg;
                state_next          = S_IDLE;
            end
            S_EVAL:
            begin
                ring_raddr = tail_reg[AW-1:0];
                if (in_line_reg || (need_room && (held_reg != '0)))
                begin
                    state_next = S_EV_CHK;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_CP_RD;
                end
            end
            S_EV_CHK:
            begin
                tail_next    = tail_reg + SW'(1);
                held_next    = held_reg - AW'(1);
                in_line_next = !((rd_q_reg == llrb_pkg::NEWLINE) || (held_reg == AW'(1)));
                state_next   = S_EVAL;
            end
            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                ring_we   = 1'b1;
                head_next = head_reg + SW'(1);
                held_next = held_reg + AW'(1);
                cnt_next  = cnt_reg + FW'(1);
                if ((cnt_reg + FW'(1)) == len_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CP_RD;
                end
            end
            S_DONE:
            begin
                rsp_valid_next      = 1'b1;
                rsp_next.read_byte  = '0;
                rsp_next.read_valid = 1'b0;
                rsp_next.head_seq   = head_reg;
                rsp_next.tail_seq   = tail_reg;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            fill_reg      <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            disc_reg      <= 1'b0;
            in_line_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            disc_reg      <= disc_next;
            in_line_reg   <= in_line_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        rsp_reg <= rsp_next;
    end

    // ring: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            log_ring[head_reg[AW-1:0]] <= ls_q_reg;
        end
        rd_q_reg <= log_ring[ring_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            line_store[fill_reg[LSW-1:0]] <= ls_wdata;
        end
        ls_q_reg <= line_store[cnt_reg[LSW-1:0]];
    end

endmodule

// File: rtl/llrb_checker.sv
module llrb_checker #(
    parameter int LOG_DEPTH = 16384
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input llrb_pkg::llrb_rsp_t rsp
);

    logic [llrb_pkg::SEQ_W-1:0] span;

    assign span = rsp.head_seq - rsp.tail_seq;

    // stalled result blocks new beats
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !req_ready)
        else $error("request taken while result stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (span < llrb_pkg::SEQ_W'(LOG_DEPTH)))
        else $error("held span exceeds ring");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.read_valid) |-> (rsp.read_byte == 8'd0))
        else $error("non-zero byte on miss or push");

    // one beat in flight: the next beat is taken only once its result is out
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (rsp_valid || !req_ready))
        else $error("second request accepted before result");

endmodule

bind line_log_ring_buffer_core llrb_checker #(
    .LOG_DEPTH(LOG_DEPTH)
) u_llrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
